// ----- rtl/core/mfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared field widths and mode codes for the feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

	localparam int MODE_W  = 2;
	localparam int PID_W   = 6;
	localparam int LEVEL_W = 3;
	localparam int QUANT_W = 8;

	localparam int IN_BITS  = MODE_W + PID_W + LEVEL_W;
	localparam int OUT_BITS = 1 + PID_W + LEVEL_W + QUANT_W + 1 + 1;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADMIT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WAKE  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

	localparam logic [QUANT_W-1:0] QUANT_CAP = 8'd255;

	typedef struct packed {
		logic                 rejected;
		logic                 queues_empty;
		logic [QUANT_W-1:0]   quantum_left;
		logic [LEVEL_W-1:0]   running_level;
		logic [PID_W-1:0]     running_id;
		logic                 running_valid;
	} status_t;

endpackage

// ----- rtl/core/multilevel_feedback_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_unit
// Multilevel feedback queue scheduler over a linked process table.
// ----------------------------------------------------------------------------
// Input stream (s_*): one beat per scheduling event: tick, admit or wake.
// Output stream (m_*): one status beat per input beat, in order, giving the
// running process, its level and quantum, whether the ready queues are empty
// and whether a push was refused.
// Queue links live in a synchronous RAM (one read and one write port,
// registered read data); heads, tails and queued flags are flip-flops.
// Mode 3 goes straight to the status beat; a push is checked for refusal
// (id out of range, already queued or running), then walks the target
// queue from its old tail, one link read at a time through the RAM port,
// and links the process in ascending id order.
// A tick decrements the quantum, requeues an expired process one level down
// (at most to the last), requeues a running process that a lower-numbered
// level preempts, then dispatches the best level's head when nothing runs.
// One event is in work at a time; s_tready is high while the block is idle,
// also while a finished beat waits on m_tready.
// If the receiver stalls, the finished beat is held and the next event's
// result waits in its last state until the output register frees.
// Reset (arst_n low) empties all queues and stops the running process; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_unit
	import mfs_pkg::*;
#(
	parameter int MAX_PROCS  = 64,
	parameter int NUM_LEVELS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [1:0] mode, [7:2] proc_id, [10:8] start_level, rest zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] running_valid, [6:1] running_id, [9:7] running_level,
	// [17:10] quantum_left, [18] queues_empty, [19] rejected, rest zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IW = $clog2(MAX_PROCS);
	localparam int LW = $clog2(MAX_PROCS + 1);
	localparam int VW = $clog2(NUM_LEVELS);
	localparam logic [LW-1:0] NIL = LW'(MAX_PROCS);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_PUSH     = 4'd1;
	localparam logic [3:0] S_TICK     = 4'd2;
	localparam logic [3:0] S_EQ_START = 4'd3;
	localparam logic [3:0] S_EQ_WAIT  = 4'd4;
	localparam logic [3:0] S_EQ_CMP   = 4'd5;
	localparam logic [3:0] S_EQ_LINK  = 4'd6;
	localparam logic [3:0] S_SEL      = 4'd7;
	localparam logic [3:0] S_DEQ      = 4'd8;
	localparam logic [3:0] S_DEQ_WAIT = 4'd9;
	localparam logic [3:0] S_MARK     = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	logic [3:0]          state_q;
	logic [MODE_W-1:0]   mode_q;
	logic [PID_W-1:0]    pid_q;
	logic [VW-1:0]       lvl_q;
	logic                rej_q;

	logic [LW-1:0]       head_q  [NUM_LEVELS];
	logic [LW-1:0]       tail_q  [NUM_LEVELS];
	logic [LW-1:0]       otail_q [NUM_LEVELS];
	logic [MAX_PROCS-1:0] queued_q;

	logic                run_q;
	logic [LW-1:0]       run_pid_q;
	logic [VW-1:0]       run_lvl_q;
	logic [QUANT_W-1:0]  quant_q;

	logic [LW-1:0]       e_pid_q;
	logic [VW-1:0]       e_lvl_q;
	logic                e_tick_q;
	logic [LW-1:0]       prev_q;
	logic [LW-1:0]       cur_q;
	logic [VW-1:0]       best_q;

	logic                out_valid_q;
	status_t             out_q;

	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [LW-1:0]       mem_wdata;
	logic [IW-1:0]       mem_raddr;
	logic [LW-1:0]       mem_rdata;

	logic                best_found;
	logic [VW-1:0]       best_lvl;
	logic                all_empty;
	logic [VW-1:0]       in_lvl;
	logic [QUANT_W-1:0]  quant_dec;
	logic [VW-1:0]       demote_lvl;
	logic                walk_on;
	logic                out_load;

	mfs_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_PROCS)
	) u_link_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		best_found = 1'b0;
		best_lvl   = '0;
		all_empty  = 1'b1;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (head_q[l] != NIL) begin
				best_found = 1'b1;
				best_lvl   = VW'(l);
				all_empty  = 1'b0;
			end
		end
	end

	assign in_lvl = (32'(s_tdata[10:8]) > NUM_LEVELS - 1) ? VW'(NUM_LEVELS - 1)
		: VW'(s_tdata[10:8]);
	assign quant_dec  = (quant_q != '0) ? quant_q - 1'b1 : '0;
	assign demote_lvl = (32'(run_lvl_q) + 1 < NUM_LEVELS) ? run_lvl_q + 1'b1 : run_lvl_q;
	assign walk_on    = (cur_q != NIL) && (32'(cur_q) < 32'(e_pid_q));
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = IW'(e_pid_q);
		mem_wdata = cur_q;
		mem_raddr = IW'(otail_q[e_lvl_q]);
		case (state_q)
			S_EQ_CMP: begin
				mem_raddr = IW'(cur_q);
				mem_we    = !walk_on;
			end
			S_EQ_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = IW'(prev_q);
				mem_wdata = e_pid_q;
			end
			S_DEQ: begin
				mem_raddr = IW'(head_q[best_q]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			queued_q    <= '0;
			run_q       <= 1'b0;
			run_pid_q   <= '0;
			run_lvl_q   <= '0;
			quant_q     <= '0;
			out_valid_q <= 1'b0;
			e_tick_q    <= 1'b0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l]  <= NIL;
				tail_q[l]  <= NIL;
				otail_q[l] <= NIL;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q <= s_tdata[1:0];
						pid_q  <= s_tdata[7:2];
						lvl_q  <= in_lvl;
						rej_q  <= 1'b0;
						if (s_tdata[1:0] == MODE_TICK) begin
							state_q <= S_TICK;
						end else if (s_tdata[1:0] == MODE_ADMIT ||
							s_tdata[1:0] == MODE_WAKE) begin
							state_q <= S_PUSH;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_PUSH: begin
					e_pid_q  <= LW'(pid_q);
					e_lvl_q  <= (mode_q == MODE_ADMIT) ? lvl_q : '0;
					e_tick_q <= 1'b0;
					if (32'(pid_q) >= MAX_PROCS || queued_q[IW'(pid_q)] ||
						(run_q && run_pid_q == LW'(pid_q))) begin
						rej_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_EQ_START;
					end
				end
				S_TICK: begin
					state_q <= S_SEL;
					if (run_q) begin
						quant_q <= quant_dec;
						if (quant_dec == '0) begin
							// expired: demote and requeue
							e_pid_q   <= run_pid_q;
							e_lvl_q   <= demote_lvl;
							e_tick_q  <= 1'b1;
							run_lvl_q <= demote_lvl;
							run_q     <= 1'b0;
							run_pid_q <= '0;
							state_q   <= S_EQ_START;
						end
					end
				end
				S_EQ_START: begin
					prev_q <= otail_q[e_lvl_q];
					if (otail_q[e_lvl_q] == NIL) begin
						cur_q   <= head_q[e_lvl_q];
						state_q <= S_EQ_CMP;
					end else begin
						state_q <= S_EQ_WAIT;
					end
				end
				S_EQ_WAIT: begin
					cur_q   <= mem_rdata;
					state_q <= S_EQ_CMP;
				end
				S_EQ_CMP: begin
					if (walk_on) begin
						prev_q  <= cur_q;
						state_q <= S_EQ_WAIT;
					end else begin
						queued_q[IW'(e_pid_q)] <= 1'b1;
						if (cur_q == NIL) begin
							tail_q[e_lvl_q] <= e_pid_q;
						end
						if (prev_q == NIL) begin
							head_q[e_lvl_q] <= e_pid_q;
							state_q <= e_tick_q ? S_SEL : S_DONE;
						end else begin
							state_q <= S_EQ_LINK;
						end
					end
				end
				S_EQ_LINK: begin
					state_q <= e_tick_q ? S_SEL : S_DONE;
				end
				S_SEL: begin
					if (!best_found || (run_q && run_lvl_q <= best_lvl)) begin
						state_q <= S_MARK;
					end else if (run_q) begin
						// preempt: requeue the running process at its level
						e_pid_q   <= run_pid_q;
						e_lvl_q   <= run_lvl_q;
						e_tick_q  <= 1'b1;
						run_q     <= 1'b0;
						run_pid_q <= '0;
						quant_q   <= '0;
						state_q   <= S_EQ_START;
					end else begin
						best_q  <= best_lvl;
						state_q <= S_DEQ;
					end
				end
				S_DEQ: begin
					cur_q   <= head_q[best_q];
					state_q <= S_DEQ_WAIT;
				end
				S_DEQ_WAIT: begin
					head_q[best_q] <= mem_rdata;
					if (mem_rdata == NIL) begin
						tail_q[best_q] <= NIL;
					end
					queued_q[IW'(cur_q)] <= 1'b0;
					run_q     <= 1'b1;
					run_pid_q <= cur_q;
					run_lvl_q <= best_q;
					quant_q   <= (32'(best_q) < 8) ? QUANT_W'(1) << best_q : QUANT_CAP;
					state_q   <= S_MARK;
				end
				S_MARK: begin
					for (int l = 0; l < NUM_LEVELS; l++) begin
						otail_q[l] <= tail_q[l];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_q.running_valid  <= run_q;
						out_q.running_id     <= run_q ? PID_W'(run_pid_q) : '0;
						out_q.running_level  <= run_q ? LEVEL_W'(run_lvl_q) : '0;
						out_q.quantum_left   <= run_q ? quant_q : '0;
						out_q.queues_empty   <= all_empty;
						out_q.rejected       <= rej_q;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

endmodule

// ----- rtl/core/mfs_ram.sv -----
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/mfs_checker.sv -----
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks on the scheduler's status stream.
// ----------------------------------------------------------------------------
module mfs_checker
	import mfs_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed under stall");

	// no running process: id, level and quantum read zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[17:1] == '0)
		else $error("idle status carries running fields");

	// a running process never shows an exhausted quantum
	a_quant_live: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[17:10] != '0)
		else $error("running process with zero quantum");

	// padding above the status fields stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_BITS] == '0)
		else $error("status beat padding not zero");

endmodule

bind multilevel_feedback_scheduler_unit mfs_checker u_mfs_checker (.*);

// ----- dv/tb_multilevel_feedback_scheduler_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_scheduler_unit
// Streams tick, admit and wake events into the scheduler and checks every
// status beat against a behavioural predictor of the ready queues.
// ----------------------------------------------------------------------------
module tb_multilevel_feedback_scheduler_unit;
	import mfs_pkg::*;

	localparam int NPROC = 64;
	localparam int NLEV  = 8;
	localparam int NIL   = NPROC;
	localparam int WDOG_LIMIT = 4000;

	typedef struct packed {
		logic [LEVEL_W-1:0] lvl;
		logic [PID_W-1:0]   pid;
		logic [MODE_W-1:0]  mode;
	} event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	multilevel_feedback_scheduler_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// scheduler image
	int  link_tab [NPROC];
	int  lvl_tab  [NPROC];
	bit  queued   [NPROC];
	int  head_q   [NLEV];
	int  tail_old [NLEV];
	bit  run_on;
	int  run_pid;
	int  quant;

	event_t  pending_events [$];
	status_t status_expected [$];
	int  errors = 0;
	int  wdog = 0;
	bit  calm = 1'b0;
	bit  hold_send = 1'b0;
	bit  done_feed = 1'b0;

	function automatic void sched_insert(input int pid, input int lv);
		int prev, cur, g;
		prev = tail_old[lv];
		cur = (prev == NIL) ? head_q[lv] : link_tab[prev];
		g = 0;
		while (cur < NPROC && cur < pid && g < NPROC) begin
			prev = cur;
			cur = link_tab[cur];
			g++;
		end
		link_tab[pid] = cur;
		if (prev == NIL) head_q[lv] = pid;
		else link_tab[prev] = pid;
		lvl_tab[pid] = lv;
		queued[pid] = 1'b1;
	endfunction

	function automatic void sched_tick();
		int best, lv, c, prev, cur;
		best = NLEV;
		if (run_on) begin
			if (quant > 0) quant--;
			if (quant == 0) begin
				lv = lvl_tab[run_pid];
				lv = (lv + 1 < NLEV) ? lv + 1 : NLEV - 1;
				sched_insert(run_pid, lv);
				run_on = 1'b0;
				run_pid = 0;
			end
		end
		for (int l = NLEV - 1; l >= 0; l--)
			if (head_q[l] != NIL) best = l;
		if (best < NLEV && run_on) begin
			if (lvl_tab[run_pid] <= best) begin
				best = NLEV;
			end else begin
				sched_insert(run_pid, lvl_tab[run_pid]);
				run_on = 1'b0;
				run_pid = 0;
				quant = 0;
			end
		end
		if (best < NLEV) begin
			c = head_q[best];
			head_q[best] = link_tab[c];
			link_tab[c] = NIL;
			queued[c] = 1'b0;
			run_on = 1'b1;
			run_pid = c;
			quant = (1 << best) > 255 ? 255 : (1 << best);
		end
		for (int l = 0; l < NLEV; l++) begin
			prev = NIL;
			cur = head_q[l];
			while (cur < NPROC) begin
				prev = cur;
				cur = link_tab[cur];
			end
			tail_old[l] = prev;
		end
	endfunction

	function automatic status_t sched_apply(input event_t ev);
		status_t st;
		bit rej;
		rej = 1'b0;
		if (ev.mode == MODE_TICK) begin
			sched_tick();
		end else if (ev.mode == MODE_ADMIT || ev.mode == MODE_WAKE) begin
			if (queued[ev.pid] || (run_on && run_pid == ev.pid)) rej = 1'b1;
			else sched_insert(ev.pid, ev.mode == MODE_ADMIT ? int'(ev.lvl) : 0);
		end
		st = '0;
		st.running_valid = run_on;
		st.running_id    = run_on ? run_pid[PID_W-1:0] : '0;
		st.running_level = run_on ? lvl_tab[run_pid][LEVEL_W-1:0] : '0;
		st.quantum_left  = run_on ? quant[QUANT_W-1:0] : '0;
		st.queues_empty  = 1'b1;
		for (int l = 0; l < NLEV; l++)
			if (head_q[l] != NIL) st.queues_empty = 1'b0;
		st.rejected = rej;
		return st;
	endfunction

	function automatic event_t mk_event(input logic [1:0] m, input int p, input int lv);
		event_t e;
		e.mode = m;
		e.pid = p[PID_W-1:0];
		e.lvl = lv[LEVEL_W-1:0];
		return e;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 16);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				status_expected.push_back(sched_apply(event_t'(s_tdata[IN_BITS-1:0])));
				void'(pending_events.pop_front());
			end
			if ((s_tvalid && !s_tready)) begin
				// hold beat
			end else if (pending_events.size() > 0 && !hold_send && !idle_now()) begin
				s_tvalid <= 1'b1;
				s_tdata <= IN_TDATA_W'(pending_events[0]);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		status_t got, exp_st;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = status_t'(m_tdata[OUT_BITS-1:0]);
				if (status_expected.size() == 0) begin
					$error("status beat with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					exp_st = status_expected.pop_front();
					if (got.running_valid !== exp_st.running_valid) begin
						$error("running_valid exp %0d got %0d", exp_st.running_valid,
							got.running_valid);
						errors++;
					end
					if (got.running_id !== exp_st.running_id) begin
						$error("running_id exp %0d got %0d", exp_st.running_id, got.running_id);
						errors++;
					end
					if (got.running_level !== exp_st.running_level) begin
						$error("running_level exp %0d got %0d", exp_st.running_level,
							got.running_level);
						errors++;
					end
					if (got.quantum_left !== exp_st.quantum_left) begin
						$error("quantum_left exp %0d got %0d", exp_st.quantum_left,
							got.quantum_left);
						errors++;
					end
					if (got.queues_empty !== exp_st.queues_empty) begin
						$error("queues_empty exp %0d got %0d", exp_st.queues_empty,
							got.queues_empty);
						errors++;
					end
					if (got.rejected !== exp_st.rejected) begin
						$error("rejected exp %0d got %0d", exp_st.rejected, got.rejected);
						errors++;
					end
				end
			end
			m_tready <= !idle_now();
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
			else wdog <= wdog + 1;
			if (wdog >= WDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int r, p;
		for (int i = 0; i < NPROC; i++) begin
			link_tab[i] = NIL;
			lvl_tab[i] = 0;
			queued[i] = 1'b0;
		end
		for (int l = 0; l < NLEV; l++) begin
			head_q[l] = NIL;
			tail_old[l] = NIL;
		end
		run_on = 1'b0;
		run_pid = 0;
		quant = 0;

		// directed: empty tick, extremes, duplicates, mode 3, demotion
		pending_events.push_back(mk_event(MODE_TICK, 63, 7));
		pending_events.push_back(mk_event(MODE_ADMIT, 63, 7));
		pending_events.push_back(mk_event(MODE_ADMIT, 0, 0));
		pending_events.push_back(mk_event(MODE_ADMIT, 0, 3));
		pending_events.push_back(mk_event(MODE_WAKE, 42, 5));
		pending_events.push_back(mk_event(MODE_WAKE, 21, 2));
		pending_events.push_back(mk_event(MODE_RSVD, 21, 7));
		pending_events.push_back(mk_event(MODE_TICK, 0, 0));
		pending_events.push_back(mk_event(MODE_ADMIT, 0, 1));
		pending_events.push_back(mk_event(MODE_ADMIT, 10, 6));
		for (int i = 0; i < 14; i++)
			pending_events.push_back(mk_event(MODE_TICK, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_events.size() == 0 && status_expected.size() == 0);
		// once every status beat has drained, hold the sender off before the random phase
		hold_send = 1'b1;
		repeat (20) @(posedge clk);
		hold_send = 1'b0;

		for (int b = 0; b < 700; b++) begin
			r = $urandom_range(99);
			p = (r < 10) ? $urandom_range(7) : $urandom_range(63);
			if (r < 45) pending_events.push_back(mk_event(MODE_TICK, $urandom_range(63),
				$urandom_range(7)));
			else if (r < 75) pending_events.push_back(mk_event(MODE_ADMIT, p,
				$urandom_range(7)));
			else if (r < 95) pending_events.push_back(mk_event(MODE_WAKE, p,
				$urandom_range(7)));
			else pending_events.push_back(mk_event(MODE_RSVD, p, $urandom_range(7)));
			if (b == 300) begin
				wait (pending_events.size() == 0);
				calm = 1'b1;
			end
			if (b == 450) begin
				wait (pending_events.size() == 0);
				calm = 1'b0;
			end
		end

		wait (pending_events.size() == 0 && status_expected.size() == 0);
		repeat (2 * NPROC + 20) @(posedge clk);
		if (errors == 0 && status_expected.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
